>>> rtl/c8pf_pkg.sv
// Package: shared types, constants and the CRC-8 byte update for the packet framer.
`timescale 1ns / 1ps
package c8pf_pkg;

	localparam logic [7:0] SYNC_MARK   = 8'hFE;
	localparam logic [7:0] TYPE_DATA   = 8'hDD;
	localparam logic [7:0] TYPE_PARITY = 8'hFF;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam logic [7:0] CRC_INIT    = 8'h00;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       is_parity;
		logic [7:0] frame_number;
		logic [7:0] chunk_number;
		logic [7:0] packet_index;
	} framer_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
	} framer_out_t;

	// one queued slot, already classified by the front end
	typedef struct packed {
		logic [7:0] payload;
		logic       first;
		logic       last;
		logic       is_parity;
		logic [7:0] frame_number;
		logic [7:0] chunk_number;
		logic [7:0] packet_index;
	} slot_cmd_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/c8pf_in_if.sv
// Interface: input word channel of the packet framer.
`timescale 1ns / 1ps
interface c8pf_in_if;
	import c8pf_pkg::*;
	logic       valid;
	logic       ready;
	framer_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/c8pf_out_if.sv
// Interface: output word channel of the packet framer.
`timescale 1ns / 1ps
interface c8pf_out_if;
	import c8pf_pkg::*;
	logic        valid;
	logic        ready;
	framer_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/c8pf_front.sv
// Front end: accepts slot words, tracks the slot position and builds queue commands.
`timescale 1ns / 1ps
module c8pf_front
	import c8pf_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 121
) (
	input  logic        clk,
	input  logic        arst_n,
	c8pf_in_if.sink     in,
	input  logic        full,
	output logic        push,
	output slot_cmd_t   cmd
);
	localparam int SLOT_W = $clog2(PAYLOAD_BYTES);

	logic [SLOT_W-1:0] slot_q;
	logic              last;

	assign in.ready = !full;
	assign push     = in.valid && !full;
	assign last     = (slot_q == SLOT_W'(PAYLOAD_BYTES - 1));

	always_comb begin
		cmd.payload      = in.data.byte_present ? in.data.data_byte : 8'h00;
		cmd.first        = (slot_q == '0);
		cmd.last         = last;
		cmd.is_parity    = in.data.is_parity;
		cmd.frame_number = in.data.frame_number;
		cmd.chunk_number = in.data.chunk_number;
		cmd.packet_index = in.data.packet_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (push) begin
			slot_q <= last ? '0 : slot_q + 1'b1;
		end
	end

endmodule

>>> rtl/c8pf_queue.sv
// Queue: small register FIFO of slot commands between front and back end.
`timescale 1ns / 1ps
module c8pf_queue
	import c8pf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  slot_cmd_t wr_cmd,
	input  logic      pop,
	output slot_cmd_t head,
	output logic      head_valid,
	output logic      full
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	slot_cmd_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (cnt_q != '0);
	assign full       = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/c8pf_back.sv
// Back end: header, payload and CRC bytes, one per unstalled cycle, into output register.
`timescale 1ns / 1ps
module c8pf_back
	import c8pf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  slot_cmd_t  head,
	input  logic       head_valid,
	output logic       pop,
	c8pf_out_if.source out
);
	typedef enum logic [6:0] {
		ST_SYNC    = 7'b0000001,
		ST_TYPE    = 7'b0000010,
		ST_FRAME   = 7'b0000100,
		ST_CHUNK   = 7'b0001000,
		ST_INDEX   = 7'b0010000,
		ST_PAYLOAD = 7'b0100000,
		ST_CRC     = 7'b1000000
	} step_t;

	step_t       step_q;
	logic        started_q;
	step_t       cur;
	step_t       nxt;
	logic [7:0]  crc_q;
	framer_out_t out_q;
	logic        out_valid_q;
	logic        load_ok;
	logic        emit;
	logic [7:0]  byte_sel;
	logic        done;

	assign load_ok = !out_valid_q || out.ready;
	assign emit    = head_valid && load_ok;
	// a fresh head starts at the sync byte on the first slot, else at its payload
	assign cur     = started_q ? step_q : (head.first ? ST_SYNC : ST_PAYLOAD);

	always_comb begin
		byte_sel = 8'h00;
		nxt      = ST_PAYLOAD;
		done     = 1'b0;
		unique case (cur)
			ST_SYNC: begin
				byte_sel = SYNC_MARK;
				nxt      = ST_TYPE;
			end
			ST_TYPE: begin
				byte_sel = head.is_parity ? TYPE_PARITY : TYPE_DATA;
				nxt      = ST_FRAME;
			end
			ST_FRAME: begin
				byte_sel = head.frame_number;
				nxt      = ST_CHUNK;
			end
			ST_CHUNK: begin
				byte_sel = head.chunk_number;
				nxt      = ST_INDEX;
			end
			ST_INDEX: begin
				byte_sel = head.packet_index;
				nxt      = ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				byte_sel = head.payload;
				nxt      = ST_CRC;
				done     = !head.last;
			end
			ST_CRC: begin
				byte_sel = crc_q;
				nxt      = ST_PAYLOAD;
				done     = 1'b1;
			end
			default: begin
				byte_sel = 8'h00;
				nxt      = ST_PAYLOAD;
				done     = 1'b1;
			end
		endcase
	end

	assign pop       = emit && done;
	assign out.valid = out_valid_q;
	assign out.data  = out_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte   <= byte_sel;
			out_q.packet_end <= (cur == ST_CRC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_PAYLOAD;
			started_q   <= 1'b0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (load_ok) begin
				out_valid_q <= head_valid;
			end
			if (emit) begin
				started_q <= !done;
				step_q    <= nxt;
				crc_q     <= (cur == ST_CRC) ? CRC_INIT : crc8_byte(crc_q, byte_sel);
			end
		end
	end

endmodule

>>> rtl/crc8_packet_framer.sv
// Path: an accepted slot word goes into the queue; the back end loads its bytes into
// the output register. Throughput: one output byte per cycle while a slot is queued
// and the output is not stalled, set by the back end's single byte-wide output
// register; a packet of PAYLOAD_BYTES slot words gives PAYLOAD_BYTES+6 bytes.
// Reset: arst_n clears slot position, queue, running CRC and output valid; the next
// word starts a new packet.
`timescale 1ns / 1ps
module crc8_packet_framer
	import c8pf_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 121
) (
	input  logic       clk,
	input  logic       arst_n,
	c8pf_in_if.sink    in,
	c8pf_out_if.source out
);
	logic      push;
	logic      pop;
	logic      full;
	logic      head_valid;
	slot_cmd_t wr_cmd;
	slot_cmd_t head;

	c8pf_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in),
		.full   (full),
		.push   (push),
		.cmd    (wr_cmd)
	);

	c8pf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_cmd     (wr_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	c8pf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out        (out)
	);

endmodule

>>> rtl/c8pf_checker.sv
// Checker: packet framing assertions on the framer's output port, with its bind.
`timescale 1ns / 1ps
module c8pf_checker
	import c8pf_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 121
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       packet_end
);
	localparam int PKT_LEN = PAYLOAD_BYTES + 6;
	localparam int POS_W   = $clog2(PKT_LEN);

	logic [POS_W-1:0] pos_q;
	logic             acc;

	assign acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (acc) begin
			pos_q <= packet_end ? '0 : pos_q + 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(packet_end))
		else $error("output word changed while stalled");

	a_sync_first: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pos_q == '0 |-> out_byte == SYNC_MARK)
		else $error("packet does not open with sync byte");

	a_type_second: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pos_q == POS_W'(1) |-> out_byte == TYPE_DATA || out_byte == TYPE_PARITY)
		else $error("bad packet type byte");

	a_end_place: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> packet_end == (pos_q == POS_W'(PKT_LEN - 1)))
		else $error("packet end flag at wrong position");

endmodule

bind crc8_packet_framer c8pf_checker #(
	.PAYLOAD_BYTES(PAYLOAD_BYTES)
) u_c8pf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out.valid),
	.out_ready  (out.ready),
	.out_byte   (out.data.out_byte),
	.packet_end (out.data.packet_end)
);

>>> test/crc8_packet_framer_test.sv
// Testbench for crc8_packet_framer: random slot words against a packet and CRC-8 predictor.
`timescale 1ns / 1ps
module crc8_packet_framer_test;
	import c8pf_pkg::*;

	localparam int PKT_SLOTS   = 121;
	localparam int TOTAL_WORDS = 260;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;

	logic clk;
	logic arst_n;

	c8pf_in_if  in_ch ();
	c8pf_out_if out_ch ();

	crc8_packet_framer #(
		.PAYLOAD_BYTES(PKT_SLOTS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (in_ch),
		.out   (out_ch)
	);

	framer_in_t  slot_words[$];
	framer_out_t framed_bytes[$];

	int         slot_pos;
	logic [7:0] pkt_crc;
	int         words_taken;
	int         idle_cycles;
	int         mismatches;
	logic       in_taken;

	// MSB-first CRC-8, poly 0x07, no reflection
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function void send_byte(input logic [7:0] b);
		framer_out_t r;
		r.out_byte   = b;
		r.packet_end = 1'b0;
		framed_bytes = {framed_bytes, r};
		pkt_crc = crc8_step(pkt_crc, b);
	endfunction

	function void frame_slot(input framer_in_t w);
		framer_out_t r;
		if (slot_pos == 0) begin
			pkt_crc = CRC_INIT;
			send_byte(SYNC_MARK);
			send_byte(w.is_parity ? TYPE_PARITY : TYPE_DATA);
			send_byte(w.frame_number);
			send_byte(w.chunk_number);
			send_byte(w.packet_index);
		end
		send_byte(w.byte_present ? w.data_byte : 8'h00);
		slot_pos++;
		if (slot_pos == PKT_SLOTS) begin
			r.out_byte   = pkt_crc;
			r.packet_end = 1'b1;
			framed_bytes = {framed_bytes, r};
			slot_pos = 0;
			pkt_crc  = CRC_INIT;
		end
	endfunction

	// thirds of the run: sender 6%/receiver 55%, then swapped, then no idling
	function automatic int idle_pct(input bit sender);
		int phase;
		phase = words_taken * 3 / TOTAL_WORDS;
		case (phase)
			0: return sender ? 6 : 55;
			1: return sender ? 55 : 6;
			default: return 0;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// stimulus: directed words at the head of the first packet, then random packets
	initial begin
		framer_in_t w;
		int         pos;
		int         pkt;
		int         fill_len;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.data    = '0;
		out_ch.ready  = 1'b0;
		slot_pos      = 0;
		pkt_crc       = CRC_INIT;
		words_taken   = 0;
		mismatches    = 0;
		fill_len      = PKT_SLOTS;
		for (int i = 0; i < TOTAL_WORDS; i++) begin
			pos = i % PKT_SLOTS;
			pkt = i / PKT_SLOTS;
			w.data_byte    = 8'($urandom_range(0, 255));
			w.is_parity    = 1'($urandom_range(0, 1));
			w.frame_number = 8'($urandom_range(0, 255));
			w.chunk_number = 8'($urandom_range(0, 255));
			w.packet_index = 8'($urandom_range(0, 255));
			if (pos == 0)
				fill_len = $urandom_range(1, PKT_SLOTS);
			// payload first, padding after, with a few slots flipped
			w.byte_present = (pos < fill_len) ^ ($urandom_range(0, 7) == 0);
			if (pos == 0) begin
				w.is_parity = (pkt % 2 == 0);
				if (pkt == 1) begin
					w.frame_number = 8'h00;
					w.chunk_number = 8'h00;
					w.packet_index = 8'h00;
				end
			end
			if (i == 0) begin
				w.data_byte    = 8'hFF;
				w.byte_present = 1'b1;
				w.frame_number = 8'hFF;
				w.chunk_number = 8'hFF;
				w.packet_index = 8'hFF;
			end else if (i == 1) begin
				// absent slot with nonzero data, header fields that must be ignored
				w.data_byte    = 8'hFF;
				w.byte_present = 1'b0;
				w.is_parity    = 1'b0;
				w.frame_number = 8'h00;
				w.chunk_number = 8'h00;
				w.packet_index = 8'h00;
			end else if (i == 2) begin
				w.data_byte    = 8'h00;
				w.byte_present = 1'b1;
			end else if (i == 3) begin
				w.data_byte    = 8'h00;
				w.byte_present = 1'b0;
			end else if (i < 12) begin
				w.data_byte    = 8'h01 << (i - 4);
				w.byte_present = 1'b1;
			end else if (i < 18) begin
				w.byte_present = i[0];
			end
			slot_words = {slot_words, w};
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (words_taken < TOTAL_WORDS || framed_bytes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// driver: new word only once the previous one is gone
	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (slot_words.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
				in_ch.valid <= 1'b1;
				in_ch.data  <= slot_words.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
		out_ch.ready <= arst_n && ($urandom_range(0, 99) >= idle_pct(1'b0));
	end

	// monitor: predict on input words, check output words, watch for a hang
	always @(posedge clk or negedge arst_n) begin
		framer_out_t want;
		if (!arst_n) begin
			in_taken    <= 1'b0;
			idle_cycles = 0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				frame_slot(in_ch.data);
				words_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (framed_bytes.size() == 0) begin
					$display("%0t: unexpected word: out_byte %02h packet_end %0b", $time,
						out_ch.data.out_byte, out_ch.data.packet_end);
					mismatches++;
				end else begin
					want = framed_bytes.pop_front();
					if (out_ch.data.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %02h actual %02h", $time,
							want.out_byte, out_ch.data.out_byte);
						mismatches++;
					end
					if (out_ch.data.packet_end !== want.packet_end) begin
						$display("%0t: packet_end expected %0b actual %0b", $time,
							want.packet_end, out_ch.data.packet_end);
						mismatches++;
					end
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule
